// ----- sv/multi_channel_watchdog_core_assert.svh -----
// Assertion helpers for the watchdog core. Each use expects clk and rst_n in scope.
`ifndef MULTI_CHANNEL_WATCHDOG_CORE_ASSERT_SVH
`define MULTI_CHANNEL_WATCHDOG_CORE_ASSERT_SVH

// Same-cycle implication.
`define MCWD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MCWD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mcwd_pkg.sv -----
`default_nettype none

package mcwd_pkg;

    localparam int TMO_W = 17;

    // Request codes
    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_OPEN    = 3'd1;
    localparam logic [2:0] REQ_WRITE   = 3'd2;
    localparam logic [2:0] REQ_FEED    = 3'd3;
    localparam logic [2:0] REQ_SET_TMO = 3'd4;
    localparam logic [2:0] REQ_STATUS  = 3'd5;
    localparam logic [2:0] REQ_RELEASE = 3'd6;
    localparam logic [2:0] REQ_DOWN    = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOT_OPEN = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEFAULT_TMO = 2'd0;
    localparam logic [1:0] CFG_NO_WAY_OUT  = 2'd1;
    localparam logic [1:0] CFG_SUPP_RST    = 2'd2;
    localparam logic [1:0] CFG_SIG_EXPIRE  = 2'd3;

    localparam logic [TMO_W-1:0] TMO_FALLBACK = 17'd5;
    localparam logic [TMO_W-1:0] TMO_MAX      = 17'd65536;
    localparam logic [7:0]       MAGIC_BYTE   = 8'h56;
    localparam logic [4:0]       MAX_REPORTS  = 5'd16;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [3:0]       channel;
        logic [TMO_W-1:0] new_timeout;
        logic [7:0]       data_byte;
        logic             byte_valid;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [3:0]       result_channel;
        logic             channel_dead;
        logic [TMO_W-1:0] timeout_value;
        logic             expired;
        logic             signal_owner;
        logic             restart_request;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic [TMO_W-1:0] open_tmo;
        logic             no_way_out;
        logic             suppress_restart;
        logic             signal_on_expire;
    } cfg_t;

    function automatic logic tmo_ok(input logic [TMO_W-1:0] t);
        return (t != '0) && (t <= TMO_MAX);
    endfunction

endpackage

`default_nettype wire

// ----- sv/mcwd_cfg.sv -----
`default_nettype none

module mcwd_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [1:0]          wr_index,
    input  wire logic [16:0]         wr_data,
    output mcwd_pkg::cfg_t           cfg
);
    import mcwd_pkg::*;

    logic [TMO_W-1:0] def_tmo_reg;
    logic             nwo_reg;
    logic             supp_reg;
    logic             sig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_tmo_reg <= TMO_FALLBACK;
            nwo_reg     <= 1'b0;
            supp_reg    <= 1'b0;
            sig_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_DEFAULT_TMO: def_tmo_reg <= wr_data;
                CFG_NO_WAY_OUT:  nwo_reg     <= wr_data[0];
                CFG_SUPP_RST:    supp_reg    <= wr_data[0];
                CFG_SIG_EXPIRE:  sig_reg     <= wr_data[0];
                default:         nwo_reg     <= nwo_reg;
            endcase
        end
    end

    // Fall back to the safe timeout when the default is out of range.
    always_comb
    begin
        cfg.open_tmo         = tmo_ok(def_tmo_reg) ? def_tmo_reg : TMO_FALLBACK;
        cfg.no_way_out       = nwo_reg;
        cfg.suppress_restart = supp_reg;
        cfg.signal_on_expire = sig_reg;
    end

endmodule

`default_nettype wire

// ----- sv/multi_channel_watchdog_core.sv -----
// Channel | Signals                              | Word
// request | req_valid, req_stall, req            | req_t, one command or tick
// result  | rsp_valid, rsp_stall, rsp            | rsp_t, one result
// config  | cfg_valid, cfg_ready, cfg_index/data | register write, always ready
//
// Tick: the walk over the timer memory, one entry a cycle while the walk is not held,
//       then the hand-off of the final expiry word when a channel expires.
// Open: the search over the in-use flags from the allocation pointer, then the hand-off.
// Other commands: update from the entry read at accept, then hand-off (Down has no read).
// Reset clears all channel flags and the allocation pointer; timer memory needs no clear.
// A stalled result side holds the final word in hand-off, and holds the walk only when a
// second expiry must be handed over.
`default_nettype none

module multi_channel_watchdog_core #(
    parameter int NUM_CHANNELS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_stall,
    input  wire mcwd_pkg::req_t req,
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    output mcwd_pkg::rsp_t    rsp,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [16:0]  cfg_data
);
    import mcwd_pkg::*;

    localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW = IW + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TICK  = 5'b00010,
        S_OPEN  = 5'b00100,
        S_CMD   = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    function automatic logic [3:0] chan4(input logic [IW-1:0] idx);
        logic [IW+3:0] ext;
        ext = {4'b0, idx};
        return ext[3:0];
    endfunction

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
        return (idx == IW'(NUM_CHANNELS - 1)) ? '0 : idx + 1'b1;
    endfunction

    cfg_t cfg;

    state_t state_reg, state_next;
    logic [NUM_CHANNELS-1:0] in_use_reg, in_use_next;
    logic [NUM_CHANNELS-1:0] dead_reg, dead_next;
    logic [NUM_CHANNELS-1:0] orphan_reg, orphan_next;
    logic [NUM_CHANNELS-1:0] armed_reg, armed_next;
    logic [IW-1:0] next_slot_reg, next_slot_next;

    req_t req_reg, req_next;
    rsp_t pend_reg, pend_next;
    logic pend_vld_reg, pend_vld_next;
    rsp_t rsp_reg, rsp_next;
    logic rsp_vld_reg, rsp_vld_next;

    logic [CW-1:0] iss_reg, iss_next;
    logic [IW-1:0] p_idx_reg, p_idx_next;
    logic          p_vld_reg, p_vld_next;
    logic [4:0]    rep_cnt_reg, rep_cnt_next;
    logic [IW-1:0] srch_idx_reg, srch_idx_next;
    logic [CW-1:0] srch_cnt_reg, srch_cnt_next;

    logic [TMO_W-1:0] tmo_mem [NUM_CHANNELS];
    logic [TMO_W-1:0] rem_mem [NUM_CHANNELS];
    logic [TMO_W-1:0] rd_tmo_reg, rd_rem_reg;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             tmo_we, rem_we;
    logic [IW-1:0]    tmo_waddr, rem_waddr;
    logic [TMO_W-1:0] tmo_wdata, rem_wdata;

    logic             accept;
    logic             rsp_free;
    logic             live, hit, report, hold_walk;
    logic [TMO_W-1:0] dec;
    logic [IW-1:0]    ci;
    logic [IW+3:0]    chn_ext;
    logic [IW+3:0]    req_chn_ext;
    logic             chn_in_range, chn_open;

    mcwd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_vld_reg || !rsp_stall;

    assign chn_ext      = {{IW{1'b0}}, req_reg.channel};
    assign req_chn_ext  = {{IW{1'b0}}, req.channel};
    assign ci           = chn_ext[IW-1:0];
    assign chn_in_range = ({3'b0, req_reg.channel} < 7'(NUM_CHANNELS));
    assign chn_open     = chn_in_range && in_use_reg[ci] && !orphan_reg[ci];

    assign live      = p_vld_reg && in_use_reg[p_idx_reg] && !dead_reg[p_idx_reg];
    assign dec       = rd_rem_reg - TMO_W'(rd_rem_reg != '0);
    assign hit       = live && (dec == '0);
    assign report    = hit && (rep_cnt_reg < MAX_REPORTS);
    assign hold_walk = report && pend_vld_reg && !rsp_free;

    always_comb
    begin
        state_next     = state_reg;
        in_use_next    = in_use_reg;
        dead_next      = dead_reg;
        orphan_next    = orphan_reg;
        armed_next     = armed_reg;
        next_slot_next = next_slot_reg;
        req_next       = req_reg;
        pend_next      = pend_reg;
        pend_vld_next  = pend_vld_reg;
        rsp_next       = rsp_reg;
        rsp_vld_next   = rsp_vld_reg && rsp_stall;
        iss_next       = iss_reg;
        p_idx_next     = p_idx_reg;
        p_vld_next     = p_vld_reg;
        rep_cnt_next   = rep_cnt_reg;
        srch_idx_next  = srch_idx_reg;
        srch_cnt_next  = srch_cnt_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        tmo_we         = 1'b0;
        tmo_waddr      = '0;
        tmo_wdata      = '0;
        rem_we         = 1'b0;
        rem_waddr      = '0;
        rem_wdata      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                    unique case (req.req_type)
                        REQ_TICK:
                        begin
                            rd_en        = 1'b1;
                            rd_addr      = '0;
                            iss_next     = CW'(1);
                            p_idx_next   = '0;
                            p_vld_next   = 1'b1;
                            rep_cnt_next = '0;
                            state_next   = S_TICK;
                        end
                        REQ_OPEN:
                        begin
                            srch_idx_next = next_slot_reg;
                            srch_cnt_next = '0;
                            state_next    = S_OPEN;
                        end
                        REQ_DOWN:
                        begin
                            dead_next                 = dead_reg | in_use_reg;
                            pend_next                 = '0;
                            pend_next.status          = ST_OK;
                            pend_next.channel_dead    = 1'b1;
                            pend_vld_next             = 1'b1;
                            state_next                = S_FLUSH;
                        end
                        default:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = req_chn_ext[IW-1:0];
                            state_next = S_CMD;
                        end
                    endcase
                end
            end

            S_TICK:
            begin
                if (p_vld_reg)
                begin
                    if (!hold_walk)
                    begin
                        if (live)
                        begin
                            rem_we    = 1'b1;
                            rem_waddr = p_idx_reg;
                            rem_wdata = dec;
                        end
                        if (hit)
                        begin
                            dead_next[p_idx_reg] = 1'b1;
                        end
                        if (report)
                        begin
                            // hand the earlier expiry over, it is not the final one
                            if (pend_vld_reg)
                            begin
                                rsp_next      = pend_reg;
                                rsp_next.last = 1'b0;
                                rsp_vld_next  = 1'b1;
                            end
                            pend_next.status          = ST_OK;
                            pend_next.result_channel  = chan4(p_idx_reg);
                            pend_next.channel_dead    = 1'b1;
                            pend_next.timeout_value   = rd_tmo_reg;
                            pend_next.expired         = 1'b1;
                            pend_next.signal_owner    = cfg.signal_on_expire
                                                        && !orphan_reg[p_idx_reg];
                            pend_next.restart_request = !cfg.suppress_restart;
                            pend_next.last            = 1'b0;
                            pend_vld_next             = 1'b1;
                            rep_cnt_next              = rep_cnt_reg + 5'd1;
                        end
                        // advance the walk
                        if (iss_reg < CW'(NUM_CHANNELS))
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = iss_reg[IW-1:0];
                            p_idx_next = iss_reg[IW-1:0];
                            iss_next   = iss_reg + 1'b1;
                        end
                        else
                        begin
                            p_vld_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    state_next = pend_vld_reg ? S_FLUSH : S_IDLE;
                end
            end

            S_OPEN:
            begin
                if (!in_use_reg[srch_idx_reg])
                begin
                    in_use_next[srch_idx_reg] = 1'b1;
                    dead_next[srch_idx_reg]   = 1'b0;
                    orphan_next[srch_idx_reg] = 1'b0;
                    armed_next[srch_idx_reg]  = 1'b0;
                    tmo_we         = 1'b1;
                    tmo_waddr      = srch_idx_reg;
                    tmo_wdata      = cfg.open_tmo;
                    rem_we         = 1'b1;
                    rem_waddr      = srch_idx_reg;
                    rem_wdata      = cfg.open_tmo;
                    next_slot_next = wrap_inc(srch_idx_reg);
                    pend_next                = '0;
                    pend_next.status         = ST_OK;
                    pend_next.result_channel = chan4(srch_idx_reg);
                    pend_next.timeout_value  = cfg.open_tmo;
                    pend_vld_next            = 1'b1;
                    state_next               = S_FLUSH;
                end
                else if (srch_cnt_reg == CW'(NUM_CHANNELS - 1))
                begin
                    pend_next        = '0;
                    pend_next.status = ST_NO_FREE;
                    pend_vld_next    = 1'b1;
                    state_next       = S_FLUSH;
                end
                else
                begin
                    srch_idx_next = wrap_inc(srch_idx_reg);
                    srch_cnt_next = srch_cnt_reg + 1'b1;
                end
            end

            S_CMD:
            begin
                pend_next                = '0;
                pend_next.result_channel = req_reg.channel;
                pend_vld_next            = 1'b1;
                state_next               = S_FLUSH;
                if (!chn_open)
                begin
                    pend_next.status       = ST_NOT_OPEN;
                    pend_next.channel_dead = 1'b1;
                end
                else
                begin
                    pend_next.status        = ST_OK;
                    pend_next.channel_dead  = dead_reg[ci];
                    pend_next.timeout_value = rd_tmo_reg;
                    unique case (req_reg.req_type)
                        REQ_WRITE, REQ_FEED:
                        begin
                            if (req_reg.req_type == REQ_FEED || req_reg.byte_valid)
                            begin
                                if (!dead_reg[ci])
                                begin
                                    rem_we    = 1'b1;
                                    rem_waddr = ci;
                                    rem_wdata = rd_tmo_reg;
                                end
                                if (req_reg.req_type == REQ_WRITE && !cfg.no_way_out
                                    && req_reg.data_byte == MAGIC_BYTE)
                                begin
                                    armed_next[ci] = 1'b1;
                                end
                            end
                        end
                        REQ_SET_TMO:
                        begin
                            if (!tmo_ok(req_reg.new_timeout))
                            begin
                                pend_next.status = ST_RANGE;
                            end
                            else
                            begin
                                tmo_we    = 1'b1;
                                tmo_waddr = ci;
                                tmo_wdata = req_reg.new_timeout;
                                rem_we    = 1'b1;
                                rem_waddr = ci;
                                rem_wdata = req_reg.new_timeout;
                                pend_next.timeout_value = req_reg.new_timeout;
                            end
                        end
                        REQ_RELEASE:
                        begin
                            orphan_next[ci] = 1'b1;
                            if (armed_reg[ci] || dead_reg[ci])
                            begin
                                dead_next[ci]          = 1'b1;
                                in_use_next[ci]        = 1'b0;
                                pend_next.channel_dead = 1'b1;
                            end
                        end
                        default:
                        begin
                            pend_next.status = ST_OK;
                        end
                    endcase
                end
            end

            S_FLUSH:
            begin
                if (rsp_free)
                begin
                    rsp_next      = pend_reg;
                    rsp_next.last = 1'b1;
                    rsp_vld_next  = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_use_reg    <= '0;
            dead_reg      <= '0;
            orphan_reg    <= '0;
            armed_reg     <= '0;
            next_slot_reg <= '0;
            pend_vld_reg  <= 1'b0;
            rsp_vld_reg   <= 1'b0;
            iss_reg       <= '0;
            p_vld_reg     <= 1'b0;
            rep_cnt_reg   <= '0;
            srch_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            dead_reg      <= dead_next;
            orphan_reg    <= orphan_next;
            armed_reg     <= armed_next;
            next_slot_reg <= next_slot_next;
            pend_vld_reg  <= pend_vld_next;
            rsp_vld_reg   <= rsp_vld_next;
            iss_reg       <= iss_next;
            p_vld_reg     <= p_vld_next;
            rep_cnt_reg   <= rep_cnt_next;
            srch_cnt_reg  <= srch_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pend_reg     <= pend_next;
        rsp_reg      <= rsp_next;
        p_idx_reg    <= p_idx_next;
        srch_idx_reg <= srch_idx_next;
    end

    // Timer memories: one write port each, one shared registered read port.
    always_ff @(posedge clk)
    begin
        if (tmo_we)
        begin
            tmo_mem[tmo_waddr] <= tmo_wdata;
        end
        if (rem_we)
        begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        if (rd_en)
        begin
            rd_tmo_reg <= tmo_mem[rd_addr];
            rd_rem_reg <= rem_mem[rd_addr];
        end
    end

    `include "multi_channel_watchdog_core_assert.svh"

    `MCWD_ASSERT_IMP(a_orphan_freed_dead, 1'b1,
        (orphan_reg & ~in_use_reg & ~dead_reg) == '0, "freed orphan channel is not dead")
    `MCWD_ASSERT_IMP(a_idle_no_pending, state_reg == S_IDLE, !pend_vld_reg,
        "pending result left in idle")
    `MCWD_ASSERT_IMP(a_report_cap, 1'b1, rep_cnt_reg <= MAX_REPORTS,
        "expiry report count over limit")
    `MCWD_ASSERT_NXT(a_busy_after_cmd, accept && req.req_type != REQ_TICK, req_stall,
        "command accepted without going busy")
    `MCWD_ASSERT_IMP(a_expiry_word, rsp_vld_reg && rsp_reg.expired,
        rsp_reg.channel_dead && rsp_reg.status == ST_OK, "expiry word malformed")

endmodule

`default_nettype wire
